FILE: hdl/xs128p_pkg.sv
// xs128p_pkg: shared types, constants and the microcode table of the
// xorshift128+ random source. No dependencies.
`default_nettype none

package xs128p_pkg;

  // Payload widths
  localparam int WORD_W   = 64;
  localparam int BOUND_W  = 32;
  localparam int KIND_W   = 2;
  localparam int LEN_W    = 5;
  localparam int IDX_W    = 2;
  localparam int STEP_W   = 5;

  // Generator constants
  localparam logic [WORD_W-1:0] PI_A = 64'h243F6A8885A308D3;
  localparam logic [WORD_W-1:0] PI_B = 64'h13198A2E03707344;
  localparam int SHL_X = 23;
  localparam int SHR_X = 17;
  localparam int SHR_Y = 26;

  // Reseed walks the state one byte per step
  localparam int SEED_BYTES = 16;
  localparam int BYTE_IDX_W = $clog2(SEED_BYTES);
  localparam logic [LEN_W-1:0] SEED_LEN_MAX = LEN_W'(SEED_BYTES);
  localparam logic [LEN_W-1:0] SEED_LEN_RST = LEN_W'(SEED_BYTES);

  // Rejection sampling gives up after this many draws
  localparam int DRAW_CNT_W = 5;
  localparam logic [DRAW_CNT_W-1:0] MAX_DRAWS = DRAW_CNT_W'(16);

  // Remainder unit: 64-bit dividend, 32-bit divisor, one bit per cycle
  localparam int DIV_CNT_W = $clog2(WORD_W);

  typedef enum logic [KIND_W-1:0] {
    KIND_RESEED  = 2'd0,
    KIND_RAW     = 2'd1,
    KIND_BOUNDED = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SEED_LOW  = 2'd0,
    REG_SEED_HIGH = 2'd1,
    REG_SEED_LEN  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RS_CLR,
    OP_RS_BYTE,
    OP_CLR_CNT,
    OP_START_LIM,
    OP_LOAD_LIM,
    OP_DRAW,
    OP_START_RES,
    OP_PUT_REM,
    OP_PUT_R,
    OP_PUT_ZERO
  } op_t;

  // Sequencing conditions
  typedef enum logic [3:0] {
    C_NEXT,      // step + 1
    C_GOTO,      // target
    C_WAIT_IN,   // hold until a request beat, then step + 1
    C_KIND0,     // target if reseed, else step + 1
    C_KIND1,     // target if raw draw, else step + 1
    C_KIND3,     // target if unused kind, else step + 1
    C_SMALL,     // target if bound below two, else step + 1
    C_REJECT,    // target if draw rejected and draws remain, else step + 1
    C_RS_MORE,   // target while reseed bytes remain, else step + 1
    C_DIV_BUSY,  // hold while remainder unit runs, then step + 1
    C_OUT_BUSY   // hold while result register is occupied, then target
  } cond_t;

  typedef struct packed {
    logic              in_rdy;
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    kind_t kind;
    logic  below_two;
    logic  reject;
    logic  rs_more;
    logic  out_free;
  } stat_t;

  // Program labels
  localparam logic [STEP_W-1:0] L_FETCH = 5'd0;
  localparam logic [STEP_W-1:0] L_DRAW  = 5'd8;
  localparam logic [STEP_W-1:0] L_RS    = 5'd13;
  localparam logic [STEP_W-1:0] L_RAW   = 5'd15;
  localparam logic [STEP_W-1:0] L_ZERO  = 5'd17;

  function automatic ctrl_t cw(input logic rdy, input op_t op, input cond_t cond,
                               input logic [STEP_W-1:0] target);
    ctrl_t w;
    w.in_rdy = rdy;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Microcode ROM
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = cw(1'b0, OP_NONE, C_GOTO, L_FETCH);
    unique case (step)
      5'd0:  w = cw(1'b1, OP_NONE,      C_WAIT_IN,  L_FETCH);
      5'd1:  w = cw(1'b0, OP_RS_CLR,    C_KIND0,    L_RS);
      5'd2:  w = cw(1'b0, OP_NONE,      C_KIND1,    L_RAW);
      5'd3:  w = cw(1'b0, OP_NONE,      C_KIND3,    L_FETCH);
      5'd4:  w = cw(1'b0, OP_CLR_CNT,   C_SMALL,    L_ZERO);
      5'd5:  w = cw(1'b0, OP_START_LIM, C_NEXT,     L_FETCH);
      5'd6:  w = cw(1'b0, OP_NONE,      C_DIV_BUSY, L_FETCH);
      5'd7:  w = cw(1'b0, OP_LOAD_LIM,  C_NEXT,     L_FETCH);
      5'd8:  w = cw(1'b0, OP_DRAW,      C_NEXT,     L_FETCH);
      5'd9:  w = cw(1'b0, OP_NONE,      C_REJECT,   L_DRAW);
      5'd10: w = cw(1'b0, OP_START_RES, C_NEXT,     L_FETCH);
      5'd11: w = cw(1'b0, OP_NONE,      C_DIV_BUSY, L_FETCH);
      5'd12: w = cw(1'b0, OP_PUT_REM,   C_OUT_BUSY, L_FETCH);
      5'd13: w = cw(1'b0, OP_RS_BYTE,   C_RS_MORE,  L_RS);
      5'd14: w = cw(1'b0, OP_NONE,      C_GOTO,     L_FETCH);
      5'd15: w = cw(1'b0, OP_DRAW,      C_NEXT,     L_FETCH);
      5'd16: w = cw(1'b0, OP_PUT_R,     C_OUT_BUSY, L_FETCH);
      5'd17: w = cw(1'b0, OP_PUT_ZERO,  C_OUT_BUSY, L_FETCH);
      default: w = cw(1'b0, OP_NONE,    C_GOTO,     L_FETCH);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/xs128p_if.sv
// Valid/ready channel interfaces of the xorshift128+ random source:
// request, response and configuration write. Depends on xs128p_pkg.
`default_nettype none

interface xs128p_req_if;
  logic                              valid;
  logic                              ready;
  logic [xs128p_pkg::KIND_W-1:0]     kind;
  logic [xs128p_pkg::BOUND_W-1:0]    bound;
  modport source (output valid, kind, bound, input ready);
  modport sink   (input valid, kind, bound, output ready);
endinterface

interface xs128p_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [xs128p_pkg::WORD_W-1:0]     value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface xs128p_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [xs128p_pkg::IDX_W-1:0]      index;
  logic [xs128p_pkg::WORD_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/xs128p_div.sv
// Iterative remainder unit: 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle. Depends on xs128p_pkg.
`default_nettype none

module xs128p_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [xs128p_pkg::WORD_W-1:0]    dividend,
  input  wire logic [xs128p_pkg::BOUND_W-1:0]   divisor,
  output logic                                  busy,
  output logic [xs128p_pkg::BOUND_W-1:0]        rem
);

  localparam int NW = xs128p_pkg::WORD_W;
  localparam int DW = xs128p_pkg::BOUND_W;
  localparam int CW = xs128p_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    trial = {rem, num[NW-1]};
    diff  = trial - {1'b0, den};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[NW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= diff[DW-1:0];
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/xs128p_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on xs128p_pkg.
`default_nettype none

module xs128p_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic                      div_busy,
  input  wire xs128p_pkg::stat_t         stat,
  output xs128p_pkg::ctrl_t              ctrl
);

  localparam int SW = xs128p_pkg::STEP_W;

  logic [SW-1:0] step;
  logic [SW-1:0] step_next;
  logic [SW-1:0] step_inc;

  // Fetch the control word of the current step
  assign ctrl     = xs128p_pkg::ucode(step);
  assign step_inc = step + 1'b1;

  // Pick the next step
  always_comb begin
    step_next = step_inc;
    unique case (ctrl.cond)
      xs128p_pkg::C_NEXT:     step_next = step_inc;
      xs128p_pkg::C_GOTO:     step_next = ctrl.target;
      xs128p_pkg::C_WAIT_IN:  step_next = accept ? step_inc : step;
      xs128p_pkg::C_KIND0:
        step_next = (stat.kind == xs128p_pkg::KIND_RESEED) ? ctrl.target : step_inc;
      xs128p_pkg::C_KIND1:
        step_next = (stat.kind == xs128p_pkg::KIND_RAW) ? ctrl.target : step_inc;
      xs128p_pkg::C_KIND3:
        step_next = (stat.kind == xs128p_pkg::KIND_UNUSED) ? ctrl.target : step_inc;
      xs128p_pkg::C_SMALL:    step_next = stat.below_two ? ctrl.target : step_inc;
      xs128p_pkg::C_REJECT:   step_next = stat.reject ? ctrl.target : step_inc;
      xs128p_pkg::C_RS_MORE:  step_next = stat.rs_more ? ctrl.target : step_inc;
      xs128p_pkg::C_DIV_BUSY: step_next = div_busy ? step : step_inc;
      xs128p_pkg::C_OUT_BUSY: step_next = stat.out_free ? ctrl.target : step;
      default:                step_next = xs128p_pkg::L_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= xs128p_pkg::L_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/xs128p_dp.sv
// Datapath: generator state, seed registers, rejection limit, draw
// counter and the response register. Depends on xs128p_pkg.
`default_nettype none

module xs128p_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic [xs128p_pkg::KIND_W-1:0]    req_kind,
  input  wire logic [xs128p_pkg::BOUND_W-1:0]   req_bound,
  input  wire logic                             cfg_we,
  input  wire logic [xs128p_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [xs128p_pkg::WORD_W-1:0]    cfg_data,
  input  wire xs128p_pkg::op_t                  op,
  input  wire logic                             out_ready,
  input  wire logic [xs128p_pkg::BOUND_W-1:0]   div_rem,
  output logic                                  div_start,
  output logic [xs128p_pkg::WORD_W-1:0]         div_dividend,
  output xs128p_pkg::stat_t                     stat,
  output logic                                  out_valid,
  output logic [xs128p_pkg::WORD_W-1:0]         out_value
);

  localparam int WW = xs128p_pkg::WORD_W;
  localparam int BW = xs128p_pkg::BOUND_W;
  localparam int LW = xs128p_pkg::LEN_W;
  localparam int IW = xs128p_pkg::BYTE_IDX_W;
  localparam logic [2*WW-1:0] PI_ALL = {xs128p_pkg::PI_B, xs128p_pkg::PI_A};

  // Generator state and seed registers
  logic [WW-1:0] word_a;
  logic [WW-1:0] word_b;
  logic [WW-1:0] seed_low;
  logic [WW-1:0] seed_high;
  logic [LW-1:0] seed_len;

  // Request and per-item working registers
  xs128p_pkg::kind_t kind;
  logic [BW-1:0]     bound;
  logic [BW-1:0]     limit;
  logic [WW-1:0]     r;
  logic [xs128p_pkg::DRAW_CNT_W-1:0] cnt;
  logic [IW-1:0]     rs_idx;
  logic [IW-1:0]     rs_pos;

  logic [WW-1:0]     x_mix;
  logic [WW-1:0]     b_next;
  logic [WW-1:0]     draw_sum;
  logic [LW-1:0]     len_eff;
  logic [LW-1:0]     pos_inc;
  logic [2*WW-1:0]   seed_all;
  logic [7:0]        rs_byte;
  logic              put;
  logic [WW-1:0]     put_value;
  logic              out_free;

  // One xorshift128+ step
  always_comb begin
    x_mix    = word_a ^ (word_a << xs128p_pkg::SHL_X);
    b_next   = x_mix ^ word_b ^ (x_mix >> xs128p_pkg::SHR_X)
               ^ (word_b >> xs128p_pkg::SHR_Y);
    draw_sum = b_next + word_b;
  end

  // Reseed byte: pi byte at rs_idx XOR seed byte at rs_pos
  always_comb begin
    if (seed_len == '0) begin
      len_eff = LW'(1);
    end else if (seed_len > xs128p_pkg::SEED_LEN_MAX) begin
      len_eff = xs128p_pkg::SEED_LEN_MAX;
    end else begin
      len_eff = seed_len;
    end
    pos_inc  = {1'b0, rs_pos} + 1'b1;
    seed_all = {seed_high, seed_low};
    rs_byte  = PI_ALL[{rs_idx, 3'b000} +: 8] ^ seed_all[{rs_pos, 3'b000} +: 8];
  end

  // Remainder unit feed
  assign div_start    = (op == xs128p_pkg::OP_START_LIM) || (op == xs128p_pkg::OP_START_RES);
  assign div_dividend = (op == xs128p_pkg::OP_START_LIM) ? ('0 - {{(WW-BW){1'b0}}, bound})
                                                         : r;

  // Status to the sequencer
  assign out_free        = !out_valid || out_ready;
  assign stat.kind       = kind;
  assign stat.below_two  = (bound[BW-1:1] == '0);
  assign stat.reject     = (r < {{(WW-BW){1'b0}}, limit}) && (cnt != xs128p_pkg::MAX_DRAWS);
  assign stat.rs_more    = (rs_idx != {IW{1'b1}});
  assign stat.out_free   = out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_low  <= '0;
      seed_high <= '0;
      seed_len  <= xs128p_pkg::SEED_LEN_RST;
    end else if (cfg_we) begin
      case (xs128p_pkg::reg_idx_t'(cfg_index))
        xs128p_pkg::REG_SEED_LOW:  seed_low  <= cfg_data;
        xs128p_pkg::REG_SEED_HIGH: seed_high <= cfg_data;
        xs128p_pkg::REG_SEED_LEN:  seed_len  <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // Generator state: advance on a draw, shift in bytes on a reseed
  always_ff @(posedge clk) begin
    if (rst) begin
      word_a <= xs128p_pkg::PI_A;
      word_b <= xs128p_pkg::PI_B;
    end else if (op == xs128p_pkg::OP_DRAW) begin
      word_a <= word_b;
      word_b <= b_next;
    end else if (op == xs128p_pkg::OP_RS_BYTE) begin
      word_b <= {rs_byte, word_b[WW-1:8]};
      word_a <= {word_b[7:0], word_a[WW-1:8]};
    end
  end

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= xs128p_pkg::KIND_UNUSED;
    end else if (accept) begin
      kind <= xs128p_pkg::kind_t'(req_kind);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bound <= req_bound;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (op)
      xs128p_pkg::OP_RS_CLR: begin
        rs_idx <= '0;
        rs_pos <= '0;
      end
      xs128p_pkg::OP_RS_BYTE: begin
        rs_idx <= rs_idx + 1'b1;
        rs_pos <= (pos_inc >= len_eff) ? '0 : pos_inc[IW-1:0];
      end
      xs128p_pkg::OP_CLR_CNT: cnt <= '0;
      xs128p_pkg::OP_LOAD_LIM: limit <= div_rem;
      xs128p_pkg::OP_DRAW: begin
        r   <= draw_sum;
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // Response register
  always_comb begin
    put       = 1'b0;
    put_value = '0;
    case (op)
      xs128p_pkg::OP_PUT_REM: begin
        put       = out_free;
        put_value = {{(WW-BW){1'b0}}, div_rem};
      end
      xs128p_pkg::OP_PUT_R: begin
        put       = out_free;
        put_value = r;
      end
      xs128p_pkg::OP_PUT_ZERO: begin
        put       = out_free;
        put_value = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_value <= put_value;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/xorshift128plus_random_source.sv
// Top level of the xorshift128+ random source: microcode sequencer,
// datapath and remainder unit. Depends on xs128p_pkg and xs128p_if.
//
//   channel  modport  payload               beat
//   req      sink     kind[1:0] bound[31:0] request: reseed, raw or bounded
//   rsp      source   value[63:0]           one per raw or bounded draw
//   cfg      sink     index[1:0] data[63:0] seed_low, seed_high, seed_len
//
// One request at a time. A reseed shifts in one state byte per step;
// a bounded draw runs the bit-serial remainder unit twice, once for the
// limit and once for the result. Reset (rst, synchronous) loads the pi
// state and default seed. A waiting result holds in the response
// register while the next request is taken; cfg is always ready.
`default_nettype none

module xorshift128plus_random_source (
  input  wire logic          clk,
  input  wire logic          rst,
  xs128p_req_if.sink         req,
  xs128p_rsp_if.source       rsp,
  xs128p_cfg_if.sink         cfg
);

  xs128p_pkg::ctrl_t ctrl;
  xs128p_pkg::stat_t stat;
  logic                                accept;
  logic                                div_start;
  logic                                div_busy;
  logic [xs128p_pkg::WORD_W-1:0]       div_dividend;
  logic [xs128p_pkg::BOUND_W-1:0]      div_rem;
  logic [xs128p_pkg::BOUND_W-1:0]      bound_q;

  // Handshakes
  assign req.ready = ctrl.in_rdy;
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;

  xs128p_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .div_busy (div_busy),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  xs128p_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_kind     (req.kind),
    .req_bound    (req.bound),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .op           (ctrl.op),
    .out_ready    (rsp.ready),
    .div_rem      (div_rem),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .stat         (stat),
    .out_valid    (rsp.valid),
    .out_value    (rsp.value)
  );

  // Divisor is the latched bound, held in the unit from start
  always_ff @(posedge clk) begin
    if (accept) begin
      bound_q <= req.bound;
    end
  end

  xs128p_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (bound_q),
    .busy     (div_busy),
    .rem      (div_rem)
  );

endmodule

`default_nettype wire
